@@ design/mcar_pkg.sv @@
// Package for the midpoint circle arc rasterizer: widths, types, opcodes,
// result slot constants and the arc slot map. No dependencies.
package mcar_pkg;

    localparam int COORD_WIDTH = 10;
    localparam int OFF_WIDTH   = COORD_WIDTH + 1;
    localparam int PIX_WIDTH   = COORD_WIDTH + 2;
    localparam int DEC_WIDTH   = COORD_WIDTH + 6;
    localparam int COLOR_WIDTH = 16;
    localparam int SLOT_WIDTH  = 3;

    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    localparam logic [SLOT_WIDTH-1:0] LAST_FULL_SLOT = 3'd7;
    localparam logic [SLOT_WIDTH-1:0] LAST_ARC_SLOT  = 3'd3;

    typedef logic [COORD_WIDTH-1:0]        coord_t;
    typedef logic signed [OFF_WIDTH-1:0]   off_t;
    typedef logic signed [PIX_WIDTH-1:0]   pix_t;
    typedef logic signed [DEC_WIDTH-1:0]   dec_t;
    typedef logic [COLOR_WIDTH-1:0]        color_t;
    typedef logic [SLOT_WIDTH-1:0]         slot_t;

    // Everything the output side needs to emit one step transaction
    typedef struct packed {
        logic   done;
        logic   arc;
        off_t   off_x;
        off_t   off_y;
        coord_t org_x;
        coord_t org_y;
        off_t   win_lo;
        off_t   win_hi;
        color_t color;
    } snap_t;

    // Arc mode emits the upper half: full-circle slots 3, 2, 7, 6 in that order
    function automatic slot_t arc_slot(input slot_t k);
        slot_t s;
        case (k[1:0])
            2'd0:    s = 3'd3;
            2'd1:    s = 3'd2;
            2'd2:    s = 3'd7;
            default: s = 3'd6;
        endcase
        return s;
    endfunction

endpackage

@@ design/mcar_core.sv @@
// Iteration state of the midpoint circle: latches a figure on start and
// advances the decision value on each step. Depends on mcar_pkg.
module mcar_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  logic                op,
    input  mcar_pkg::coord_t    center_x,
    input  mcar_pkg::coord_t    center_y,
    input  mcar_pkg::coord_t    radius,
    input  logic                arc_mode,
    input  mcar_pkg::off_t      window_low,
    input  mcar_pkg::off_t      window_high,
    input  mcar_pkg::color_t    color,
    output logic                issue,
    output mcar_pkg::snap_t     snap
);

    mcar_pkg::coord_t org_x_reg, org_y_reg;
    mcar_pkg::off_t   off_x_reg, off_y_reg, off_x_next, off_y_next;
    mcar_pkg::dec_t   dec_reg, dec_next;
    mcar_pkg::off_t   win_lo_reg, win_hi_reg;
    mcar_pkg::color_t color_reg;
    logic             arc_reg, busy_reg, busy_next;
    logic             finished;
    mcar_pkg::dec_t   dec_start, dec_x4, dec_xy4;

    assign finished  = !busy_reg || (off_x_reg > off_y_reg);
    assign issue     = fire && (op == mcar_pkg::OP_STEP);

    assign dec_start = mcar_pkg::dec_t'(3)
                     - (mcar_pkg::dec_t'($signed({1'b0, radius})) <<< 1);
    assign dec_x4    = mcar_pkg::dec_t'(off_x_reg) <<< 2;
    assign dec_xy4   = (mcar_pkg::dec_t'(off_x_reg) - mcar_pkg::dec_t'(off_y_reg)) <<< 2;

    always_comb
    begin
        snap.done   = finished;
        snap.arc    = arc_reg;
        snap.off_x  = off_x_reg;
        snap.off_y  = off_y_reg;
        snap.org_x  = org_x_reg;
        snap.org_y  = org_y_reg;
        snap.win_lo = win_lo_reg;
        snap.win_hi = win_hi_reg;
        snap.color  = color_reg;
    end

    // Decision update uses the un-incremented x
    always_comb
    begin
        off_x_next = off_x_reg;
        off_y_next = off_y_reg;
        dec_next   = dec_reg;
        busy_next  = busy_reg;
        if (finished)
        begin
            busy_next = 1'b0;
        end
        else
        begin
            if (dec_reg < 0)
            begin
                dec_next = dec_reg + dec_x4 + mcar_pkg::dec_t'(6);
            end
            else
            begin
                dec_next   = dec_reg + dec_xy4 + mcar_pkg::dec_t'(10);
                off_y_next = off_y_reg - mcar_pkg::off_t'(1);
            end
            off_x_next = off_x_reg + mcar_pkg::off_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            org_x_reg  <= '0;
            org_y_reg  <= '0;
            off_x_reg  <= '0;
            off_y_reg  <= '0;
            dec_reg    <= '0;
            arc_reg    <= 1'b0;
            win_lo_reg <= '0;
            win_hi_reg <= '0;
            color_reg  <= '0;
            busy_reg   <= 1'b0;
        end
        else if (fire)
        begin
            if (op == mcar_pkg::OP_START)
            begin
                org_x_reg  <= center_x;
                org_y_reg  <= center_y;
                off_x_reg  <= '0;
                off_y_reg  <= mcar_pkg::off_t'({1'b0, radius});
                dec_reg    <= dec_start;
                arc_reg    <= arc_mode;
                win_lo_reg <= window_low;
                win_hi_reg <= window_high;
                color_reg  <= color;
                busy_reg   <= 1'b1;
            end
            else
            begin
                off_x_reg <= off_x_next;
                off_y_reg <= off_y_next;
                dec_reg   <= dec_next;
                busy_reg  <= busy_next;
            end
        end
    end

endmodule

@@ design/mcar_emit.sv @@
// Result serializer: holds one step's snapshot and emits its mirrored pixels,
// or a single done result, one per output transaction. Depends on mcar_pkg.
module mcar_emit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  mcar_pkg::snap_t     snap_in,
    output logic                out_valid,
    input  logic                out_ready,
    output mcar_pkg::pix_t      pixel_x,
    output mcar_pkg::pix_t      pixel_y,
    output logic                plot,
    output mcar_pkg::color_t    pixel_color,
    output logic                last,
    output logic                done_res
);

    mcar_pkg::snap_t snap_reg;
    logic            valid_reg;
    mcar_pkg::slot_t slot_reg;
    mcar_pkg::slot_t slot;
    mcar_pkg::pix_t  px, py, nx, ny, dx, dy, ox, oy, wlo, whi;
    logic            in_win;

    assign px  = mcar_pkg::pix_t'(snap_reg.off_x);
    assign py  = mcar_pkg::pix_t'(snap_reg.off_y);
    assign nx  = -px;
    assign ny  = -py;
    assign ox  = $signed({2'b00, snap_reg.org_x});
    assign oy  = $signed({2'b00, snap_reg.org_y});
    assign wlo = mcar_pkg::pix_t'(snap_reg.win_lo);
    assign whi = mcar_pkg::pix_t'(snap_reg.win_hi);

    assign slot = snap_reg.arc ? mcar_pkg::arc_slot(slot_reg) : slot_reg;

    always_comb
    begin
        case (slot)
            3'd0:    begin dx = px; dy = py; end
            3'd1:    begin dx = nx; dy = py; end
            3'd2:    begin dx = nx; dy = ny; end
            3'd3:    begin dx = px; dy = ny; end
            3'd4:    begin dx = py; dy = px; end
            3'd5:    begin dx = ny; dy = px; end
            3'd6:    begin dx = ny; dy = nx; end
            default: begin dx = py; dy = nx; end
        endcase
    end

    assign in_win = (dx >= wlo) && (dx <= whi);

    assign out_valid   = valid_reg;
    assign done_res    = snap_reg.done;
    assign pixel_x     = snap_reg.done ? '0 : ox + dx;
    assign pixel_y     = snap_reg.done ? '0 : oy + dy;
    assign plot        = !snap_reg.done && (!snap_reg.arc || in_win);
    assign pixel_color = snap_reg.done ? '0 : snap_reg.color;
    assign last        = snap_reg.done
                      || (slot_reg == (snap_reg.arc ? mcar_pkg::LAST_ARC_SLOT
                                                    : mcar_pkg::LAST_FULL_SLOT));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            slot_reg  <= '0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
            slot_reg  <= '0;
        end
        else if (valid_reg && out_ready)
        begin
            if (last)
            begin
                valid_reg <= 1'b0;
            end
            slot_reg <= slot_reg + mcar_pkg::slot_t'(1);
        end
    end

    // Snapshot is payload only
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            snap_reg <= snap_in;
        end
    end

endmodule

@@ design/midpoint_circle_arc_rasterizer_top.sv @@
// Midpoint circle / upper-arc rasterizer. A start transaction (op = 0) latches
// center, radius, color, mode and window and returns nothing; it restarts
// the figure even mid-circle. Each step transaction (op = 1) runs one
// midpoint iteration and returns eight mirrored pixels in full-circle mode or
// four upper-half pixels in arc mode, one result per cycle while out_ready is
// high, the final one flagged last; once x has passed y (or with no figure
// loaded) a step returns a single done result instead. The iteration itself
// finishes in the accept cycle; the single output port sets the rate, as a
// step's results leave it one at a time. The next transaction is accepted
// in the same cycle that the last result of the previous step is taken, so
// steps stream back to back with no bubble. Depends on mcar_pkg, mcar_core
// and mcar_emit.
module midpoint_circle_arc_rasterizer_top (
    input  logic                clk,
    input  logic                rst_n,
    // input channel
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                op,
    input  mcar_pkg::coord_t    center_x,
    input  mcar_pkg::coord_t    center_y,
    input  mcar_pkg::coord_t    radius,
    input  logic                arc_mode,
    input  mcar_pkg::off_t      window_low,
    input  mcar_pkg::off_t      window_high,
    input  mcar_pkg::color_t    color,
    // result channel
    output logic                out_valid,
    input  logic                out_ready,
    output mcar_pkg::pix_t      pixel_x,
    output mcar_pkg::pix_t      pixel_y,
    output logic                plot,
    output mcar_pkg::color_t    pixel_color,
    output logic                last,
    output logic                done_res
);

    logic            fire;
    logic            issue;
    mcar_pkg::snap_t snap;

    // Accept while the serializer is empty or is handing off its final result
    assign in_ready = !out_valid || (out_ready && last);
    assign fire     = in_valid && in_ready;

    mcar_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .op          (op),
        .center_x    (center_x),
        .center_y    (center_y),
        .radius      (radius),
        .arc_mode    (arc_mode),
        .window_low  (window_low),
        .window_high (window_high),
        .color       (color),
        .issue       (issue),
        .snap        (snap)
    );

    mcar_emit u_emit (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (issue),
        .snap_in     (snap),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .plot        (plot),
        .pixel_color (pixel_color),
        .last        (last),
        .done_res    (done_res)
    );

`ifndef SYNTHESIS
    // A step transaction always yields a result in the next cycle
    a_step_yields: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && op == mcar_pkg::OP_STEP) |=> out_valid)
        else $error("step transaction produced no result");

    // A start transaction never starts result traffic on its own
    a_start_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && op == mcar_pkg::OP_START && !out_valid) |=> !out_valid)
        else $error("start transaction produced a result");

    // A done result is a lone, blank, final result
    a_done_blank: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && done_res) |-> (last && !plot && pixel_x == 0 && pixel_y == 0))
        else $error("malformed done result");
`endif

endmodule

@@ tb/midpoint_circle_arc_rasterizer_top_test.sv @@
// Self-checking testbench for midpoint_circle_arc_rasterizer_top: a directed table and then
// random figures, with every result checked against a cycle-free circle predictor.
// Depends on mcar_pkg and the rasterizer RTL.
module midpoint_circle_arc_rasterizer_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import mcar_pkg::*;

    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 9;
    localparam int RANDOM_ITEMS   = 310;
    localparam int DRAIN_CYCLES   = 20;
    localparam int STALL_LIMIT    = 4000;  // well above the long receiver hold-off
    localparam int PRESSURE_HOLD  = 400;
    localparam int PRESSURE_AFTER = 200;   // results taken before the hold-off starts
    localparam int N_DIRECTED     = 25;
    localparam int COORD_MAX      = (1 << COORD_WIDTH) - 1;

    localparam logic FULL_CIRCLE = 1'b0;
    localparam logic UPPER_ARC   = 1'b1;

    // How a transaction's results are known: from the predictor, or typed in as a done item
    typedef enum logic {EXP_PREDICTED, EXP_DONE_ITEM} check_e;

    typedef struct packed {
        logic   op;
        coord_t cx;
        coord_t cy;
        coord_t rad;
        logic   arc;
        off_t   wlo;
        off_t   whi;
        color_t color;
        check_e chk;
    } cmd_t;

    typedef struct packed {
        pix_t   px;
        pix_t   py;
        logic   plot;
        color_t color;
        logic   last;
        logic   done;
    } pixel_res_t;

    localparam pixel_res_t DONE_ITEM =
        '{px: '0, py: '0, plot: 1'b0, color: '0, last: 1'b1, done: 1'b1};

    // Every block input starts at a known value
    logic   clk         = 1'b0;
    logic   rst_n       = 1'b0;
    logic   in_valid    = 1'b0;
    logic   in_ready;
    logic   op          = OP_START;
    coord_t center_x    = '0;
    coord_t center_y    = '0;
    coord_t radius      = '0;
    logic   arc_mode    = FULL_CIRCLE;
    off_t   window_low  = '0;
    off_t   window_high = '0;
    color_t color       = '0;
    logic   out_valid;
    logic   out_ready   = 1'b0;
    pix_t   pixel_x;
    pix_t   pixel_y;
    logic   plot;
    color_t pixel_color;
    logic   last;
    logic   done_res;

    // Travels with the payload so the acceptance monitor knows how to check it
    check_e cur_chk = EXP_PREDICTED;

    midpoint_circle_arc_rasterizer_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .op          (op),
        .center_x    (center_x),
        .center_y    (center_y),
        .radius      (radius),
        .arc_mode    (arc_mode),
        .window_low  (window_low),
        .window_high (window_high),
        .color       (color),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .plot        (plot),
        .pixel_color (pixel_color),
        .last        (last),
        .done_res    (done_res)
    );

    always #CLK_HALF clk = ~clk;

    // ------------------------------------------------------------------
    // Circle predictor: its own copy of the figure state
    // ------------------------------------------------------------------
    coord_t org_x    = '0;
    coord_t org_y    = '0;
    off_t   cur_x    = '0;
    off_t   cur_y    = '0;
    dec_t   dec      = '0;
    logic   arc_on   = 1'b0;
    off_t   win_lo   = '0;
    off_t   win_hi   = '0;
    color_t held_col = '0;
    logic   drawing  = 1'b0;

    pixel_res_t step_pixels [8];
    int         n_step_pixels;

    pixel_res_t pending_pixels [$];
    int         n_mismatch = 0;

    function automatic logic in_win(int h);
        return h >= int'(win_lo) && h <= int'(win_hi);
    endfunction

    function automatic pixel_res_t mirror_pixel(int dx, int dy, logic plot_it, logic is_last);
        pixel_res_t p;
        p.px    = pix_t'(int'(org_x) + dx);
        p.py    = pix_t'(int'(org_y) + dy);
        p.plot  = plot_it;
        p.color = held_col;
        p.last  = is_last;
        p.done  = 1'b0;
        return p;
    endfunction

    // One transaction: a start latches the figure, a step emits one set of mirrored pixels or a done item
    function automatic void advance_figure(input cmd_t c);
        int x;
        int y;
        n_step_pixels = 0;
        if (c.op == OP_START) begin
            org_x    = c.cx;
            org_y    = c.cy;
            cur_x    = '0;
            cur_y    = off_t'(c.rad);
            dec      = dec_t'(3 - 2 * int'(c.rad));
            arc_on   = c.arc;
            win_lo   = c.wlo;
            win_hi   = c.whi;
            held_col = c.color;
            drawing  = 1'b1;
            return;
        end
        if (!drawing || cur_x > cur_y) begin
            drawing        = 1'b0;
            step_pixels[0] = DONE_ITEM;
            n_step_pixels  = 1;
            return;
        end
        x = int'(cur_x);
        y = int'(cur_y);
        if (arc_on) begin
            step_pixels[0] = mirror_pixel( x, -y, in_win(x),  1'b0);
            step_pixels[1] = mirror_pixel(-x, -y, in_win(-x), 1'b0);
            step_pixels[2] = mirror_pixel( y, -x, in_win(y),  1'b0);
            step_pixels[3] = mirror_pixel(-y, -x, in_win(-y), 1'b1);
            n_step_pixels  = 4;
        end else begin
            step_pixels[0] = mirror_pixel( x,  y, 1'b1, 1'b0);
            step_pixels[1] = mirror_pixel(-x,  y, 1'b1, 1'b0);
            step_pixels[2] = mirror_pixel(-x, -y, 1'b1, 1'b0);
            step_pixels[3] = mirror_pixel( x, -y, 1'b1, 1'b0);
            step_pixels[4] = mirror_pixel( y,  x, 1'b1, 1'b0);
            step_pixels[5] = mirror_pixel(-y,  x, 1'b1, 1'b0);
            step_pixels[6] = mirror_pixel(-y, -x, 1'b1, 1'b0);
            step_pixels[7] = mirror_pixel( y, -x, 1'b1, 1'b1);
            n_step_pixels  = 8;
        end
        // Decision update uses x before the increment
        if (dec < 0) begin
            dec = dec_t'(int'(dec) + 4 * x + 6);
        end else begin
            dec   = dec_t'(int'(dec) + 4 * (x - y) + 10);
            cur_y = off_t'(y - 1);
        end
        cur_x = off_t'(x + 1);
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic cmd_t start_row(int cx, int cy, int r, logic arc, int lo, int hi,
                                       int col);
        cmd_t c;
        c.op    = OP_START;
        c.cx    = coord_t'(cx);
        c.cy    = coord_t'(cy);
        c.rad   = coord_t'(r);
        c.arc   = arc;
        c.wlo   = off_t'(lo);
        c.whi   = off_t'(hi);
        c.color = color_t'(col);
        c.chk   = EXP_PREDICTED;
        return c;
    endfunction

    function automatic cmd_t step_row(check_e chk);
        cmd_t c;
        c     = start_row(0, 0, 0, FULL_CIRCLE, 0, 0, 0);
        c.op  = OP_STEP;
        c.chk = chk;
        return c;
    endfunction

    // Every field random, so ignored fields on step transactions toggle too
    function automatic cmd_t random_cmd();
        cmd_t c;
        c.op    = 1'($urandom_range(0, 1));
        c.cx    = coord_t'($urandom_range(0, COORD_MAX));
        c.cy    = coord_t'($urandom_range(0, COORD_MAX));
        c.rad   = coord_t'($urandom_range(0, COORD_MAX));
        c.arc   = 1'($urandom_range(0, 1));
        c.wlo   = off_t'($urandom_range(0, 2 * COORD_MAX + 1));
        c.whi   = off_t'($urandom_range(0, 2 * COORD_MAX + 1));
        c.color = color_t'($urandom_range(0, 65535));
        c.chk   = EXP_PREDICTED;
        return c;
    endfunction

    // Mostly back-to-back or short gaps, now and then a long one
    function automatic int idle_len(bit burst);
        int r;
        if (burst)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    int n_sent   = 0;
    bit tx_burst = 1'b0;

    // Offer one transaction and return at the edge where it is accepted.
    // Valid stays high across back-to-back transactions.
    task automatic send_cmd(input cmd_t c);
        int gap;
        n_sent++;
        if (n_sent % 40 == 0)
            tx_burst = ($urandom_range(0, 3) == 0);
        gap = idle_len(tx_burst);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        op          <= c.op;
        center_x    <= c.cx;
        center_y    <= c.cy;
        radius      <= c.rad;
        arc_mode    <= c.arc;
        window_low  <= c.wlo;
        window_high <= c.whi;
        color       <= c.color;
        cur_chk     <= c.chk;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Random figures: a start and then roughly enough steps to finish it,
    // sometimes cut short by the next start, sometimes followed by extra steps
    task automatic run_random(input int n_items);
        cmd_t c;
        int   sent;
        int   pick;
        int   rad;
        int   n_steps;
        int   a;
        int   k;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                // stray step: done when idle, otherwise it advances the loaded figure
                c    = random_cmd();
                c.op = OP_STEP;
                send_cmd(c);
                sent++;
            end else begin
                c    = random_cmd();
                c.op = OP_START;
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    rad = $urandom_range(0, 12);
                else if (pick < 95)
                    rad = $urandom_range(13, 80);
                else
                    rad = $urandom_range(81, COORD_MAX);
                c.rad = coord_t'(rad);
                pick  = $urandom_range(0, 99);
                if (pick < 40) begin
                    // window cutting through the arc
                    a     = $urandom_range(0, rad);
                    c.wlo = off_t'(-a);
                    c.whi = off_t'($urandom_range(0, rad));
                end else if (pick < 55) begin
                    c.wlo = off_t'(-(COORD_MAX + 1));
                    c.whi = off_t'(COORD_MAX);
                end else if (pick < 65) begin
                    // empty window
                    a     = $urandom_range(1, 50);
                    c.wlo = off_t'(a);
                    c.whi = off_t'(-$urandom_range(0, 50));
                end
                send_cmd(c);
                sent++;
                n_steps = rad * 707 / 1000 + 3;
                if (n_steps > 30)
                    n_steps = $urandom_range(5, 30);
                else if ($urandom_range(0, 99) < 15)
                    n_steps = $urandom_range(1, n_steps);
                for (k = 0; k < n_steps && sent < n_items; k++) begin
                    c    = random_cmd();
                    c.op = OP_STEP;
                    send_cmd(c);
                    sent++;
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        n_mismatch++;
    endtask

    // Predict at the edge where the input transaction is accepted. Ports are
    // sampled before this edge's updates, so payload and handshake agree.
    always @(posedge clk) begin : accept_monitor
        cmd_t c;
        int   k;
        if (rst_n && in_valid && in_ready) begin
            c.op    = op;
            c.cx    = center_x;
            c.cy    = center_y;
            c.rad   = radius;
            c.arc   = arc_mode;
            c.wlo   = window_low;
            c.whi   = window_high;
            c.color = color;
            c.chk   = cur_chk;
            advance_figure(c);
            if (cur_chk == EXP_DONE_ITEM)
                pending_pixels.push_back(DONE_ITEM);
            else
                for (k = 0; k < n_step_pixels; k++)
                    pending_pixels.push_back(step_pixels[k]);
        end
    end

    // Compare each result transaction, field by field, with the oldest expectation
    always @(posedge clk) begin : result_monitor
        pixel_res_t e;
        if (rst_n && out_valid && out_ready) begin
            if (pending_pixels.size() == 0) begin
                report_mismatch("result with nothing pending (pixel_x)", int'(pixel_x), 0);
            end else begin
                e = pending_pixels.pop_front();
                if (pixel_x !== e.px)
                    report_mismatch("pixel_x", int'(pixel_x), int'(e.px));
                if (pixel_y !== e.py)
                    report_mismatch("pixel_y", int'(pixel_y), int'(e.py));
                if (plot !== e.plot)
                    report_mismatch("plot", int'(plot), int'(e.plot));
                if (pixel_color !== e.color)
                    report_mismatch("pixel_color", int'(pixel_color), int'(e.color));
                if (last !== e.last)
                    report_mismatch("last", int'(last), int'(e.last));
                if (done_res !== e.done)
                    report_mismatch("done_res", int'(done_res), int'(e.done));
            end
        end
    end

    // Receiver: drop ready for a random gap after each result, with stretches of
    // no gaps at all. Once, hold off for a long stretch so the block backs up
    // and stalls its input while the sender keeps offering.
    initial begin : result_ready_ctl
        int n_taken;
        int hold;
        bit burst;
        bit pressure_done;
        n_taken       = 0;
        hold          = 0;
        burst         = 1'b0;
        pressure_done = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            if (out_valid && out_ready) begin
                n_taken++;
                if (n_taken % 48 == 0)
                    burst = ($urandom_range(0, 3) == 0);
                hold = idle_len(burst);
                if (!pressure_done && n_taken >= PRESSURE_AFTER) begin
                    hold          = PRESSURE_HOLD;
                    pressure_done = 1'b1;
                end
            end
            if (hold > 0) begin
                out_ready <= 1'b0;
                hold--;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // Watchdog: count cycles in which neither channel moves a transaction
    int stall_cycles = 0;

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t ns: no transaction for %0d cycles", $time, STALL_LIMIT);
                $display("midpoint_circle_arc_rasterizer_top_test: FAIL");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    cmd_t directed_tbl [N_DIRECTED];

    initial begin : main_seq
        int i;
        directed_tbl = '{
            step_row(EXP_DONE_ITEM),                                    // step while idle
            start_row(0, 0, 0, FULL_CIRCLE, 0, 0, 'h0000),              // zero radius
            step_row(EXP_PREDICTED),                                    // eight center pixels
            step_row(EXP_DONE_ITEM),                                    // y went below x
            step_row(EXP_DONE_ITEM),                                    // idle again
            start_row(COORD_MAX, COORD_MAX, COORD_MAX, FULL_CIRCLE, 0, 0, 'hFFFF),
            step_row(EXP_PREDICTED),
            step_row(EXP_PREDICTED),
            // restart mid-figure, reaching negative coordinates
            start_row(0, 0, COORD_MAX, FULL_CIRCLE, -(COORD_MAX + 1), COORD_MAX, 'hA5A5),
            step_row(EXP_PREDICTED),
            // arc with the widest window: everything plotted
            start_row(512, 512, 5, UPPER_ARC, -(COORD_MAX + 1), COORD_MAX, 'h5A5A),
            step_row(EXP_PREDICTED),
            step_row(EXP_PREDICTED),
            step_row(EXP_PREDICTED),
            step_row(EXP_PREDICTED),
            step_row(EXP_DONE_ITEM),                                    // radius 5 ends here
            start_row(100, 900, 3, UPPER_ARC, 5, -5, 'h07E0),           // empty window
            step_row(EXP_PREDICTED),
            step_row(EXP_PREDICTED),
            start_row(10, 10, 2, UPPER_ARC, 0, 0, 'hF800),              // one-column window
            step_row(EXP_PREDICTED),
            step_row(EXP_PREDICTED),
            start_row(700, 300, 3, UPPER_ARC, -3, 3, 'h001F),           // window edges on +-r
            step_row(EXP_PREDICTED),
            step_row(EXP_PREDICTED)
        };

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < N_DIRECTED; i++)
            send_cmd(directed_tbl[i]);
        run_random(RANDOM_ITEMS);

        // Advance one edge so the last prediction is queued before draining
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_pixels.size() != 0)
            @(posedge clk);
        // Hold a little longer to catch any stray result
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_pixels.size() != 0)
            report_mismatch("results never delivered", 0, pending_pixels.size());

        if (n_mismatch == 0)
            $display("midpoint_circle_arc_rasterizer_top_test: PASS");
        else
            $display("midpoint_circle_arc_rasterizer_top_test: FAIL");
        $finish;
    end

endmodule
